// ----- sv/sac_pkg.sv -----
`default_nettype none

package sac_pkg;

  localparam int ADDR_W    = 31;
  localparam int CNT_W     = 32;
  localparam int CFG_W     = 4;
  localparam int CFG_IDX_W = 2;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_LINE_OFFSET = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_SET_BITS    = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_WAYS        = 2'd2;

  localparam logic [CFG_W-1:0] RST_LINE_OFFSET = 4'd6;
  localparam logic [CFG_W-1:0] RST_SET_BITS    = 4'd4;
  localparam logic [CFG_W-1:0] RST_WAYS        = 4'd4;

  typedef struct packed {
    logic clear;   // zero one row of the set memory
    logic lookup;  // latch the beat, read its set
    logic update;  // resolve hit/victim, write back, count, emit
  } cmd_t;

  typedef struct packed {
    logic clear_last;
  } sts_t;

endpackage

`default_nettype wire

// ----- sv/sac_ctrl.sv -----
`default_nettype none

module sac_ctrl (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          start,
  output logic               busy,
  output sac_pkg::cmd_t      cmd,
  input  wire sac_pkg::sts_t sts
);

  typedef enum logic [1:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_UPDATE
  } state_t;

  state_t state_r;
  state_t state_nxt;

  always_comb begin
    state_nxt  = state_r;
    cmd.clear  = 1'b0;
    cmd.lookup = 1'b0;
    cmd.update = 1'b0;
    unique case (state_r)
      ST_CLEAR: begin
        cmd.clear = 1'b1;
        if (sts.clear_last) state_nxt = ST_IDLE;
      end
      ST_IDLE: begin
        if (start) begin
          cmd.lookup = 1'b1;
          state_nxt  = ST_UPDATE;
        end
      end
      ST_UPDATE: begin
        cmd.update = 1'b1;
        state_nxt  = ST_IDLE;
      end
      default: state_nxt = ST_CLEAR;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_CLEAR;
    end else begin
      state_r <= state_nxt;
    end
  end

  assign busy = (state_r != ST_IDLE);

  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> (busy && cmd.update))
    else $error("accepted beat not followed by update");

  a_clear_done: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.clear && sts.clear_last) |=> !busy)
    else $error("block not idle after clearing pass");

  a_no_update_idle: assert property (@(posedge clk) disable iff (!rst_n)
    !busy |-> !cmd.update && !cmd.clear)
    else $error("command issued while idle");

endmodule

`default_nettype wire

// ----- sv/sac_dp.sv -----
`default_nettype none

module sac_dp #(
  parameter int MAX_SETS = 256,
  parameter int MAX_WAYS = 8
) (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  input  wire sac_pkg::cmd_t                cmd,
  output sac_pkg::sts_t                     sts,
  input  wire logic [sac_pkg::ADDR_W-1:0]   in_address,
  input  wire logic                         in_last_access,
  input  wire logic [sac_pkg::CFG_W-1:0]    line_shift,
  input  wire logic [((MAX_SETS > 1) ? $clog2(MAX_SETS) : 1)-1:0] set_mask,
  input  wire logic [MAX_WAYS-1:0]          way_en,
  output logic                              out_valid,
  output logic                              out_hit,
  output logic [sac_pkg::CNT_W-1:0]         out_hit_total,
  output logic [sac_pkg::CNT_W-1:0]         out_miss_total,
  output logic                              out_totals_final
);

  localparam int SET_AW = (MAX_SETS > 1) ? $clog2(MAX_SETS) : 1;
  localparam int RANK_W = (MAX_WAYS > 1) ? $clog2(MAX_WAYS) : 1;
  localparam int WAY_W  = (MAX_WAYS > 1) ? $clog2(MAX_WAYS) : 1;
  localparam int AW     = sac_pkg::ADDR_W;
  localparam int ENT_W  = 1 + RANK_W + AW;
  localparam int ROW_W  = MAX_WAYS * ENT_W;
  localparam logic [RANK_W-1:0] RANK_SAT = RANK_W'(MAX_WAYS - 1);
  localparam logic [SET_AW-1:0] LAST_ROW = SET_AW'(MAX_SETS - 1);

  // one row per set: per way {valid, rank, tag}
  logic [ROW_W-1:0] mem [MAX_SETS];

  logic [ROW_W-1:0]          row_r;
  logic [ROW_W-1:0]          row_nxt;
  logic [AW-1:0]             line_r;
  logic [SET_AW-1:0]         set_r;
  logic                      last_r;
  logic [SET_AW-1:0]         clr_cnt_r;
  logic [sac_pkg::CNT_W-1:0] hit_cnt_r;
  logic [sac_pkg::CNT_W-1:0] miss_cnt_r;
  logic                      out_valid_r;
  logic                      out_hit_r;
  logic                      out_final_r;

  logic [AW-1:0]     line_in;
  logic [SET_AW-1:0] set_in;

  assign line_in = in_address >> line_shift;
  assign set_in  = line_in[SET_AW-1:0] & set_mask;

  logic [AW-1:0]     tag_w   [MAX_WAYS];
  logic [RANK_W-1:0] rank_w  [MAX_WAYS];
  logic [MAX_WAYS-1:0] valid_w;
  logic [MAX_WAYS-1:0] hit_vec;
  logic [MAX_WAYS-1:0] inval_vec;
  logic              any_hit;
  logic              any_inval;
  logic [WAY_W-1:0]  hit_idx;
  logic [WAY_W-1:0]  inv_idx;
  logic [WAY_W-1:0]  lru_idx;
  logic [RANK_W-1:0] lru_rank;
  logic [WAY_W-1:0]  sel_idx;
  logic [RANK_W-1:0] old_rank;
  logic              age_all;

  always_comb begin
    for (int i = 0; i < MAX_WAYS; i++) begin
      tag_w[i]   = row_r[i*ENT_W +: AW];
      rank_w[i]  = row_r[i*ENT_W + AW +: RANK_W];
      valid_w[i] = row_r[i*ENT_W + AW + RANK_W];
      hit_vec[i]   = way_en[i] && valid_w[i] && (tag_w[i] == line_r);
      inval_vec[i] = way_en[i] && !valid_w[i];
    end
  end

  assign any_hit   = |hit_vec;
  assign any_inval = |inval_vec;

  // lowest hitting way, lowest empty way, oldest way (lowest on a tie)
  always_comb begin
    hit_idx  = '0;
    inv_idx  = '0;
    for (int i = MAX_WAYS - 1; i >= 0; i--) begin
      if (hit_vec[i])   hit_idx = WAY_W'(i);
      if (inval_vec[i]) inv_idx = WAY_W'(i);
    end
    lru_idx  = '0;
    lru_rank = rank_w[0];
    for (int i = 1; i < MAX_WAYS; i++) begin
      if (way_en[i] && (rank_w[i] > lru_rank)) begin
        lru_idx  = WAY_W'(i);
        lru_rank = rank_w[i];
      end
    end
  end

  always_comb begin
    age_all = 1'b0;
    if (any_hit) begin
      sel_idx  = hit_idx;
      old_rank = rank_w[hit_idx];
    end else if (any_inval) begin
      sel_idx  = inv_idx;
      old_rank = '0;
      age_all  = 1'b1;  // filling an empty way ages every enabled valid way below the top rank
    end else begin
      sel_idx  = lru_idx;
      old_rank = lru_rank;
    end
  end

  always_comb begin
    for (int i = 0; i < MAX_WAYS; i++) begin
      row_nxt[i*ENT_W +: ENT_W] = row_r[i*ENT_W +: ENT_W];
      if (WAY_W'(i) == sel_idx) begin
        row_nxt[i*ENT_W +: ENT_W] = {1'b1, {RANK_W{1'b0}}, line_r};
      end else if (way_en[i] && valid_w[i] && (age_all || (rank_w[i] < old_rank))
                   && (rank_w[i] < RANK_SAT)) begin
        row_nxt[i*ENT_W + AW +: RANK_W] = rank_w[i] + RANK_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.clear) begin
      mem[clr_cnt_r] <= '0;
    end else if (cmd.update) begin
      mem[set_r] <= row_nxt;
    end
    if (cmd.lookup) begin
      row_r  <= mem[set_in];
      line_r <= line_in;
      set_r  <= set_in;
      last_r <= in_last_access;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_cnt_r   <= '0;
      hit_cnt_r   <= '0;
      miss_cnt_r  <= '0;
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= cmd.update;
      if (cmd.clear) clr_cnt_r <= clr_cnt_r + SET_AW'(1);
      if (cmd.update) begin
        if (any_hit) begin
          if (hit_cnt_r != '1) hit_cnt_r <= hit_cnt_r + sac_pkg::CNT_W'(1);
        end else begin
          if (miss_cnt_r != '1) miss_cnt_r <= miss_cnt_r + sac_pkg::CNT_W'(1);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.update) begin
      out_hit_r   <= any_hit;
      out_final_r <= last_r;
    end
  end

  assign sts.clear_last   = (clr_cnt_r == LAST_ROW);
  assign out_valid        = out_valid_r;
  assign out_hit          = out_hit_r;
  assign out_hit_total    = hit_cnt_r;
  assign out_miss_total   = miss_cnt_r;
  assign out_totals_final = out_final_r;

  a_cmd_excl: assert property (@(posedge clk) disable iff (!rst_n)
    $countones({cmd.clear, cmd.lookup, cmd.update}) <= 1)
    else $error("conflicting datapath commands");

  a_hit_count: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.update && any_hit && (hit_cnt_r != '1)) |=>
      (hit_cnt_r == $past(hit_cnt_r) + sac_pkg::CNT_W'(1)) && $stable(miss_cnt_r))
    else $error("hit count did not advance by one");

  a_miss_count: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.update && !any_hit && (miss_cnt_r != '1)) |=>
      (miss_cnt_r == $past(miss_cnt_r) + sac_pkg::CNT_W'(1)) && $stable(hit_cnt_r))
    else $error("miss count did not advance by one");

endmodule

`default_nettype wire

// ----- sv/set_assoc_lru_cache_sim.sv -----
// Set-associative cache hit/miss tracker with true LRU replacement.
// Each beat: set memory read, then tag compare, rank update and write-back of the same
// row; busy stays high in between, so no new beat is taken before the write-back.
// The result strobe is registered from the update step.
// Reset: a clearing pass zeroes every row of the set memory with busy high.
// out_valid is a one-cycle strobe; the receiver cannot stall.
`default_nettype none

module set_assoc_lru_cache_sim #(
  parameter int MAX_SETS = 256,
  parameter int MAX_WAYS = 8
) (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  input  wire logic                            start,
  output logic                                 busy,
  input  wire logic [sac_pkg::ADDR_W-1:0]      in_address,
  input  wire logic                            in_last_access,
  output logic                                 out_valid,
  output logic                                 out_hit,
  output logic [sac_pkg::CNT_W-1:0]            out_hit_total,
  output logic [sac_pkg::CNT_W-1:0]            out_miss_total,
  output logic                                 out_totals_final,
  input  wire logic                            cfg_we,
  input  wire logic [sac_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  wire logic [sac_pkg::CFG_W-1:0]       cfg_data
);

  localparam int SET_AW       = (MAX_SETS > 1) ? $clog2(MAX_SETS) : 1;
  localparam int SET_BITS_MAX = $clog2(MAX_SETS + 1) - 1;

  logic [sac_pkg::CFG_W-1:0] line_off_r;
  logic [sac_pkg::CFG_W-1:0] set_bits_r;
  logic [sac_pkg::CFG_W-1:0] ways_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      line_off_r <= sac_pkg::RST_LINE_OFFSET;
      set_bits_r <= sac_pkg::RST_SET_BITS;
      ways_r     <= sac_pkg::RST_WAYS;
    end else if (cfg_we) begin
      unique case (cfg_index)
        sac_pkg::CFG_LINE_OFFSET: line_off_r <= cfg_data;
        sac_pkg::CFG_SET_BITS:    set_bits_r <= cfg_data;
        sac_pkg::CFG_WAYS:        ways_r     <= cfg_data;
        default: ;
      endcase
    end
  end

  logic [sac_pkg::CFG_W-1:0] eff_set_bits;
  logic [sac_pkg::CFG_W:0]   eff_ways;
  logic [SET_AW-1:0]         set_mask;
  logic [MAX_WAYS-1:0]       way_en;

  always_comb begin
    eff_set_bits = (set_bits_r > sac_pkg::CFG_W'(SET_BITS_MAX)) ?
                   sac_pkg::CFG_W'(SET_BITS_MAX) : set_bits_r;
    if (ways_r == '0) begin
      eff_ways = (sac_pkg::CFG_W+1)'(1);
    end else if ({1'b0, ways_r} > (sac_pkg::CFG_W+1)'(MAX_WAYS)) begin
      eff_ways = (sac_pkg::CFG_W+1)'(MAX_WAYS);
    end else begin
      eff_ways = {1'b0, ways_r};
    end
    for (int j = 0; j < SET_AW; j++) begin
      set_mask[j] = (eff_set_bits > sac_pkg::CFG_W'(j));
    end
    for (int i = 0; i < MAX_WAYS; i++) begin
      way_en[i] = ((sac_pkg::CFG_W+1)'(i) < eff_ways);
    end
  end

  sac_pkg::cmd_t cmd;
  sac_pkg::sts_t sts;

  sac_ctrl u_ctrl (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .busy  (busy),
    .cmd   (cmd),
    .sts   (sts)
  );

  sac_dp #(
    .MAX_SETS (MAX_SETS),
    .MAX_WAYS (MAX_WAYS)
  ) u_dp (
    .clk              (clk),
    .rst_n            (rst_n),
    .cmd              (cmd),
    .sts              (sts),
    .in_address       (in_address),
    .in_last_access   (in_last_access),
    .line_shift       (line_off_r),
    .set_mask         (set_mask),
    .way_en           (way_en),
    .out_valid        (out_valid),
    .out_hit          (out_hit),
    .out_hit_total    (out_hit_total),
    .out_miss_total   (out_miss_total),
    .out_totals_final (out_totals_final)
  );

endmodule

`default_nettype wire

// ----- sim/tb_set_assoc_lru_cache_sim.sv -----
`default_nettype none

module tb_set_assoc_lru_cache_sim;

  localparam int NUM_SETS   = 256;
  localparam int NUM_WAYS   = 8;
  localparam int SLOT_COUNT = NUM_SETS * NUM_WAYS;
  localparam int CYCLE_LIMIT = 400000;
  localparam int PHASE_COUNT = 12;
  localparam int PHASE_ITEMS = 160;
  // index with no register behind it, writes to it must be ignored
  localparam logic [sac_pkg::CFG_IDX_W-1:0] CFG_SPARE = 2'd3;

  typedef struct {
    bit        hit;
    bit [31:0] hit_total;
    bit [31:0] miss_total;
    bit        totals_final;
  } outcome_t;

  class lru_cache_tracker;
    bit [sac_pkg::ADDR_W-1:0] tag_mem   [SLOT_COUNT];
    bit                       valid_mem [SLOT_COUNT];
    bit [2:0]                 rank_mem  [SLOT_COUNT];
    bit [sac_pkg::CNT_W-1:0]  hit_count;
    bit [sac_pkg::CNT_W-1:0]  miss_count;
    bit [sac_pkg::CFG_W-1:0]  offset_bits;
    bit [sac_pkg::CFG_W-1:0]  set_bits;
    bit [sac_pkg::CFG_W-1:0]  way_count;
    outcome_t                 expected_outcomes[$];
    int                       mismatches;
    int                       accesses;

    function new();
      offset_bits = sac_pkg::RST_LINE_OFFSET;
      set_bits    = sac_pkg::RST_SET_BITS;
      way_count   = sac_pkg::RST_WAYS;
      hit_count   = '0;
      miss_count  = '0;
      mismatches  = 0;
      accesses    = 0;
    endfunction

    function void write_reg(logic [sac_pkg::CFG_IDX_W-1:0] idx,
                            logic [sac_pkg::CFG_W-1:0] val);
      case (idx)
        sac_pkg::CFG_LINE_OFFSET: offset_bits = val;
        sac_pkg::CFG_SET_BITS:    set_bits    = val;
        sac_pkg::CFG_WAYS:        way_count   = val;
        default: ;
      endcase
    endfunction

    // make way w most recent; valid ways ranked below old_rank age by one, up to the top rank
    function void promote(int base, int ways, int w, int old_rank);
      for (int i = 0; i < ways; i++) begin
        if (i != w && valid_mem[base + i] &&
            rank_mem[base + i] < old_rank && rank_mem[base + i] < NUM_WAYS - 1)
          rank_mem[base + i] = rank_mem[base + i] + 3'd1;
      end
      rank_mem[base + w] = '0;
    endfunction

    function void note_access(bit [sac_pkg::ADDR_W-1:0] addr, bit last);
      bit [sac_pkg::ADDR_W-1:0] line;
      int sbits, ways, base, victim, old_rank;
      bit hit;
      outcome_t res;
      line  = addr >> offset_bits;
      sbits = set_bits;
      while (sbits > 0 && (1 << sbits) > NUM_SETS) sbits--;
      ways = way_count;
      if (ways == 0) ways = 1;
      if (ways > NUM_WAYS) ways = NUM_WAYS;
      base = int'(line & ((31'd1 << sbits) - 31'd1)) * NUM_WAYS;
      hit = 1'b0;
      for (int i = 0; i < ways; i++) begin
        if (!hit && valid_mem[base + i] && tag_mem[base + i] == line) begin
          promote(base, ways, i, rank_mem[base + i]);
          hit = 1'b1;
        end
      end
      if (hit) begin
        if (hit_count != '1) hit_count++;
      end else begin
        victim = ways;
        for (int i = ways - 1; i >= 0; i--)
          if (!valid_mem[base + i]) victim = i;
        if (victim < ways) begin
          old_rank = NUM_WAYS;   // filling an empty way ages every enabled valid way below the top rank
        end else begin
          victim = 0;
          for (int i = 1; i < ways; i++)
            if (rank_mem[base + i] > rank_mem[base + victim]) victim = i;
          old_rank = rank_mem[base + victim];
        end
        tag_mem[base + victim]   = line;
        valid_mem[base + victim] = 1'b1;
        promote(base, ways, victim, old_rank);
        if (miss_count != '1) miss_count++;
      end
      res.hit          = hit;
      res.hit_total    = hit_count;
      res.miss_total   = miss_count;
      res.totals_final = last;
      expected_outcomes.push_back(res);
      accesses++;
    endfunction

    function void check_outcome(logic hit, logic [sac_pkg::CNT_W-1:0] hit_total,
                                logic [sac_pkg::CNT_W-1:0] miss_total,
                                logic totals_final);
      outcome_t want;
      if (expected_outcomes.size() == 0) begin
        $display("%0t: unexpected result beat hit=%b hits=%0d misses=%0d final=%b",
                 $time, hit, hit_total, miss_total, totals_final);
        mismatches++;
        return;
      end
      want = expected_outcomes.pop_front();
      if (hit !== want.hit) begin
        $display("%0t: hit exp %b got %b", $time, want.hit, hit);
        mismatches++;
      end
      if (hit_total !== want.hit_total) begin
        $display("%0t: hit_total exp %0d got %0d", $time, want.hit_total, hit_total);
        mismatches++;
      end
      if (miss_total !== want.miss_total) begin
        $display("%0t: miss_total exp %0d got %0d", $time, want.miss_total, miss_total);
        mismatches++;
      end
      if (totals_final !== want.totals_final) begin
        $display("%0t: totals_final exp %b got %b", $time, want.totals_final,
                 totals_final);
        mismatches++;
      end
    endfunction
  endclass

  logic                          clk = 1'b0;
  logic                          rst_n = 1'b0;
  logic                          start = 1'b0;
  logic                          busy;
  logic [sac_pkg::ADDR_W-1:0]    in_address = '0;
  logic                          in_last_access = 1'b0;
  logic                          out_valid;
  logic                          out_hit;
  logic [sac_pkg::CNT_W-1:0]     out_hit_total;
  logic [sac_pkg::CNT_W-1:0]     out_miss_total;
  logic                          out_totals_final;
  logic                          cfg_we = 1'b0;
  logic [sac_pkg::CFG_IDX_W-1:0] cfg_index = '0;
  logic [sac_pkg::CFG_W-1:0]     cfg_data = '0;

  lru_cache_tracker         tracker = new();
  int                       cycle_count = 0;
  int                       sender_idle_pct = 24;
  int                       cur_offset = sac_pkg::RST_LINE_OFFSET;
  int                       cur_set_bits = sac_pkg::RST_SET_BITS;
  bit [sac_pkg::ADDR_W-1:0] recent_addrs[$];

  set_assoc_lru_cache_sim dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .start            (start),
    .busy             (busy),
    .in_address       (in_address),
    .in_last_access   (in_last_access),
    .out_valid        (out_valid),
    .out_hit          (out_hit),
    .out_hit_total    (out_hit_total),
    .out_miss_total   (out_miss_total),
    .out_totals_final (out_totals_final),
    .cfg_we           (cfg_we),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data)
  );

  always #10 clk = ~clk;

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycle_count);
      $display("TB_ERROR");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_valid === 1'b1)
      tracker.check_outcome(out_hit, out_hit_total, out_miss_total, out_totals_final);
  end

  task automatic send_access(input bit [sac_pkg::ADDR_W-1:0] addr, input bit last);
    int gap;
    gap = 0;
    while ($urandom_range(0, 99) < sender_idle_pct && gap < 40) gap++;
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start          <= 1'b1;
    in_address     <= addr;
    in_last_access <= last;
    do @(posedge clk); while (busy !== 1'b0);
    tracker.note_access(addr, last);
  endtask

  // drop start and let every outstanding beat come back before touching config
  task automatic settle();
    start <= 1'b0;
    do @(posedge clk); while (tracker.expected_outcomes.size() != 0 || busy !== 1'b0);
    repeat (3) @(posedge clk);
  endtask

  task automatic cfg_write(input logic [sac_pkg::CFG_IDX_W-1:0] idx,
                           input logic [sac_pkg::CFG_W-1:0] val);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    tracker.write_reg(idx, val);
    if (idx == sac_pkg::CFG_LINE_OFFSET) cur_offset = val;
    if (idx == sac_pkg::CFG_SET_BITS) cur_set_bits = (val > 8) ? 8 : val;
  endtask

  task automatic apply_config(input int lo, input int sb, input int wy, input bit spare);
    settle();
    cfg_write(sac_pkg::CFG_LINE_OFFSET, lo[sac_pkg::CFG_W-1:0]);
    cfg_write(sac_pkg::CFG_SET_BITS, sb[sac_pkg::CFG_W-1:0]);
    cfg_write(sac_pkg::CFG_WAYS, wy[sac_pkg::CFG_W-1:0]);
    if (spare) cfg_write(CFG_SPARE, 4'(($urandom_range(0, 15))));
    cfg_we <= 1'b0;
  endtask

  // mostly reuse and same-set conflicts so hits and evictions dominate
  function automatic bit [sac_pkg::ADDR_W-1:0] pick_address();
    int mode, sh;
    bit [sac_pkg::ADDR_W-1:0] a;
    mode = $urandom_range(0, 99);
    if (recent_addrs.size() == 0 || mode >= 88) begin
      a = 31'($urandom);
    end else if (mode >= 78) begin
      a = 31'($urandom_range(0, 4095));
    end else begin
      a = recent_addrs[$urandom_range(0, recent_addrs.size() - 1)];
      if (mode < 42) begin
        a = a ^ (31'($urandom) & ((31'd1 << cur_offset) - 31'd1));
      end else begin
        sh = cur_offset + cur_set_bits;
        if (sh < sac_pkg::ADDR_W) a = a ^ (31'($urandom_range(1, 15)) << sh);
      end
    end
    return a;
  endfunction

  initial begin
    int lo, sb, wy;
    bit [sac_pkg::ADDR_W-1:0] a;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    // clearing pass holds busy after reset
    do @(posedge clk); while (busy !== 1'b0);

    // reset settings: fill, hit, evict, last flag and beats after it
    send_access(31'd0, 1'b0);
    send_access(31'h7FFF_FFFF, 1'b0);
    send_access(31'd5, 1'b0);
    send_access(31'd1024, 1'b0);
    send_access(31'd2048, 1'b1);
    send_access(31'd3072, 1'b0);
    send_access(31'd4096, 1'b0);
    send_access(31'd0, 1'b0);
    send_access(31'd2111, 1'b0);

    // recency tie: shrink ways so ranks diverge, then grow and push the
    // duplicate ranks to the top; the miss must evict the lower way
    apply_config(0, 8, 8, 1'b0);
    for (int k = 1; k <= 7; k++) send_access(31'(200 + 256 * k), 1'b0);
    apply_config(0, 8, 2, 1'b0);
    send_access(31'(200 + 256 * 8), 1'b0);
    apply_config(0, 8, 8, 1'b0);
    send_access(31'(200 + 256 * 9), 1'b0);
    for (int k = 2; k <= 6; k++) send_access(31'(200 + 256 * k), 1'b0);
    send_access(31'(200 + 256 * 10), 1'b0);

    for (int p = 0; p < PHASE_COUNT; p++) begin
      case (p)
        0: begin lo = 6;  sb = 4;  wy = 4;  end
        1: begin lo = 0;  sb = 0;  wy = 1;  end
        2: begin lo = 12; sb = 8;  wy = 8;  end
        3: begin lo = 15; sb = 15; wy = 0;  end
        4: begin lo = 2;  sb = 9;  wy = 15; end
        5: begin lo = 0;  sb = 8;  wy = 2;  end
        6: begin lo = 4;  sb = 3;  wy = 8;  end
        7: begin lo = 1;  sb = 2;  wy = 3;  end
        default: begin
          lo = $urandom_range(0, 15);
          sb = $urandom_range(0, 15);
          wy = $urandom_range(0, 15);
        end
      endcase
      apply_config(lo, sb, wy, p == 3 || p == 9);
      sender_idle_pct = (p < 4) ? 24 : (p < 8) ? 78 : 0;
      recent_addrs.delete();
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        a = pick_address();
        recent_addrs.push_back(a);
        if (recent_addrs.size() > 24) void'(recent_addrs.pop_front());
        send_access(a, $urandom_range(0, 99) < 3);
      end
    end

    start <= 1'b0;
    do @(posedge clk); while (tracker.expected_outcomes.size() != 0);
    repeat (10) @(posedge clk);
    $display("checked %0d accesses (%0d hits, %0d misses) over %0d cache settings",
             tracker.accesses, tracker.hit_count, tracker.miss_count, PHASE_COUNT + 3);
    if (tracker.mismatches == 0 && tracker.expected_outcomes.size() == 0) begin
      $display("TB_OK");
    end else begin
      $display("%0d mismatches, %0d results missing", tracker.mismatches,
               tracker.expected_outcomes.size());
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

`default_nettype wire
